// ===== rtl/mccf_pkg.sv =====
// Motor command CRC framer: shared constants, CRC control struct.
// No dependencies; used by mccf_crc_unit and motor_command_crc_framer.
`default_nettype none
package mccf_pkg;

	localparam int unsigned MAX_DATA   = 4;
	localparam int unsigned DATA_LIMIT = (MAX_DATA < 4) ? MAX_DATA : 4;
	localparam int unsigned CRC_W      = 14;

	localparam logic [7:0]       ADDR_OFFSET = 8'd112;
	localparam logic [7:0]       SET_CMD     = 8'd40;
	localparam logic [7:0]       ADDR_RESET  = 8'd16;
	localparam logic [6:0]       CRC7_MASK   = 7'h7f;
	localparam logic [CRC_W-1:0] CRC7_INIT   = 14'h007f;
	localparam logic [CRC_W-1:0] CRC7_POLY   = 14'h0076;
	localparam logic [CRC_W-1:0] CRC14_INIT  = 14'h3fff;
	localparam logic [CRC_W-1:0] CRC14_POLY  = 14'h22f0;
	localparam logic [CRC_W-1:0] CRC14_XOR   = 14'h3fff;

	typedef struct packed {
		logic init;
		logic update;
		logic wide;
	} crc_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/motor_command_crc_framer.sv =====
// Motor command framer top level: sequencer, output register, address register.
// Depends on mccf_pkg and mccf_crc_unit.
//
// One request becomes a packet of 4 bytes (no data) or 6 + n bytes (n data
// bytes, set mode n = 4), one beat per byte, at most 10. A byte sequencer
// drives a shared CRC unit that folds in one byte per cycle unless the
// output stalls, first over the header for the CRC-7, then over the data
// for the CRC-14. After the accept cycle the packet streams at one byte per
// cycle when out_ready stays high; in_ready returns as soon as the final
// byte enters the output register. Configuration writes take effect at
// once and are meant for idle time only.
`default_nettype none
module motor_command_crc_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [7:0]  command,
	input  wire logic [7:0]  value_byte,
	input  wire logic [2:0]  data_count,
	input  wire logic [7:0]  data0,
	input  wire logic [7:0]  data1,
	input  wire logic [7:0]  data2,
	input  wire logic [7:0]  data3,
	input  wire logic signed [14:0] set_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR,
		S_CMD,
		S_VAL,
		S_CRC7,
		S_DATA,
		S_LO,
		S_HI
	} state_t;

	state_t                     state_q;
	logic [7:0]                 addr_q;
	logic [7:0]                 cmd_q;
	logic [7:0]                 val_q;
	logic [7:0]                 data_q [4];
	logic [2:0]                 cnt_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       last_q;

	logic                       accept;
	logic                       advance;
	logic [7:0]                 emit_byte;
	logic                       emit_last;
	mccf_pkg::crc_ctrl_t        crc_ctrl;
	logic [mccf_pkg::CRC_W-1:0] crc;
	logic [mccf_pkg::CRC_W-1:0] crc14_final;
	logic                       neg;
	logic [13:0]                mag;
	logic [2:0]                 n_in;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign advance  = (state_q != S_IDLE) && (!out_valid_q || out_ready);

	assign neg         = set_value[14];
	assign mag         = neg ? (14'd0 - set_value[13:0]) : set_value[13:0];
	assign n_in        = (data_count > 3'(mccf_pkg::DATA_LIMIT)) ?
	                     3'(mccf_pkg::DATA_LIMIT) : data_count;
	assign crc14_final = crc ^ mccf_pkg::CRC14_XOR;
	assign emit_last   = (state_q == S_HI) || ((state_q == S_CRC7) && (cnt_q == 3'd0));

	always_comb begin
		case (state_q)
			S_HDR:   emit_byte = addr_q + mccf_pkg::ADDR_OFFSET;
			S_CMD:   emit_byte = cmd_q;
			S_VAL:   emit_byte = val_q;
			S_CRC7:  emit_byte = {1'b0, crc[6:0] ^ mccf_pkg::CRC7_MASK};
			S_DATA:  emit_byte = data_q[0];
			S_LO:    emit_byte = {1'b0, crc14_final[6:0]};
			S_HI:    emit_byte = {1'b0, crc14_final[13:7]};
			default: emit_byte = 8'd0;
		endcase
	end

	always_comb begin
		crc_ctrl = '0;
		case (state_q)
			S_IDLE: begin
				crc_ctrl.init = accept;
			end
			S_HDR, S_CMD, S_VAL: begin
				crc_ctrl.update = advance;
			end
			S_CRC7: begin
				crc_ctrl.init = advance;
				crc_ctrl.wide = 1'b1;
			end
			S_DATA: begin
				crc_ctrl.update = advance;
				crc_ctrl.wide   = 1'b1;
			end
			default: begin
				crc_ctrl.wide = 1'b1;
			end
		endcase
	end

	mccf_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (emit_byte),
		.crc    (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= mccf_pkg::ADDR_RESET;
		end else if (cfg_we) begin
			addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			val_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			last_q      <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				data_q[i] <= '0;
			end
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= emit_byte;
				last_q      <= emit_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HDR;
						if (mode) begin
							cmd_q     <= mccf_pkg::SET_CMD;
							val_q     <= value_byte + {7'd0, neg};
							cnt_q     <= 3'd4;
							data_q[0] <= {1'b0, mag[6:0]};
							data_q[1] <= {1'b0, mag[13:7]};
						end else begin
							cmd_q     <= command;
							val_q     <= value_byte;
							cnt_q     <= n_in;
							data_q[0] <= data0;
							data_q[1] <= data1;
						end
						data_q[2] <= data2;
						data_q[3] <= data3;
					end
				end
				S_HDR: if (advance) state_q <= S_CMD;
				S_CMD: if (advance) state_q <= S_VAL;
				S_VAL: if (advance) state_q <= S_CRC7;
				S_CRC7: begin
					if (advance) begin
						if (cnt_q == 3'd0) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_DATA;
						end
					end
				end
				S_DATA: begin
					if (advance) begin
						for (int i = 0; i < 3; i++) begin
							data_q[i] <= data_q[i+1];
						end
						cnt_q <= cnt_q - 3'd1;
						if (cnt_q == 3'd1) begin
							state_q <= S_LO;
						end
					end
				end
				S_LO: if (advance) state_q <= S_HI;
				S_HI: begin
					if (advance) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ===== rtl/mccf_crc_unit.sv =====
// Shared reflected CRC register, one byte per cycle with update set, CRC-7 or CRC-14 polynomial.
// Depends on mccf_pkg.
`default_nettype none
module mccf_crc_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mccf_pkg::crc_ctrl_t         ctrl,
	input  wire logic [7:0]                  data,
	output logic      [mccf_pkg::CRC_W-1:0]  crc
);

	logic [mccf_pkg::CRC_W-1:0] crc_q;
	logic [mccf_pkg::CRC_W-1:0] crc_next;

	always_comb begin
		logic [mccf_pkg::CRC_W-1:0] c;
		logic [mccf_pkg::CRC_W-1:0] poly;
		poly = ctrl.wide ? mccf_pkg::CRC14_POLY : mccf_pkg::CRC7_POLY;
		c = crc_q ^ {{(mccf_pkg::CRC_W-8){1'b0}}, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		crc_next = c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mccf_pkg::CRC7_INIT;
		end else if (ctrl.init) begin
			crc_q <= ctrl.wide ? mccf_pkg::CRC14_INIT : mccf_pkg::CRC7_INIT;
		end else if (ctrl.update) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule
`default_nettype wire
